### src/ght_pkg.sv
// shared types, constants and helpers for the generational handle table
// no dependencies; the core and the free map refer to this package by scoped names
package ght_pkg;

    localparam int CAPACITY_DEF = 256;

    localparam int GEN_W     = 16;
    localparam int HANDLE_W  = 32;
    localparam int BMP_W     = 16;
    localparam int BMP_SH    = 4;
    localparam int FM_WORD_W = 12;

    localparam logic [GEN_W-1:0] GEN_RESET = 16'h0001;
    localparam logic [GEN_W-1:0] GEN_MAX   = 16'hffff;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_INVALID   = 2'd2;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_LOOKUP  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_ALLOC
    } state_t;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [HANDLE_W-1:0] handle_in;
    } req_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle_out;
        logic [7:0]          slot_index;
        logic [1:0]          status;
    } rsp_t;

    // requests from the controller to the free map
    typedef struct packed {
        logic                 rd;
        logic [FM_WORD_W-1:0] rd_word;
        logic                 wr;
        logic [FM_WORD_W-1:0] wr_word;
        logic [BMP_W-1:0]     wr_data;
    } fm_cmd_t;

    typedef struct packed {
        logic [BMP_W-1:0]     rd_data;
        logic [FM_WORD_W-1:0] first_word;
        logic                 all_full;
    } fm_stat_t;

    // bits of a bitmap word that map onto real slots
    function automatic logic [BMP_W-1:0] bmp_mask(input logic [FM_WORD_W-1:0] widx,
                                                 input int capacity);
        logic [BMP_W-1:0] m;
        m = '0;
        for (int b = 0; b < BMP_W; b++)
        begin
            m[b] = ((int'(widx) * BMP_W) + b) < capacity;
        end
        return m;
    endfunction

    // lowest clear bit
    function automatic logic [BMP_SH-1:0] first_zero(input logic [BMP_W-1:0] bits);
        logic [BMP_SH-1:0] pos;
        pos = '0;
        for (int b = BMP_W - 1; b >= 0; b--)
        begin
            if (!bits[b])
            begin
                pos = BMP_SH'(b);
            end
        end
        return pos;
    endfunction

endpackage

### src/generational_handle_table_core.sv
// generational handle table top level: controller, generation ram, results
// uses ght_pkg, ght_ram and ght_free_map
//
//  channel   signals                 direction  transfer
//  request   start, busy, request    in         start high while busy low
//  result    done, result            out        done high for one cycle
//
// lookup and release go through a ram read and then a check / write-back step;
// allocate adds one more read of the generation ram at the slot the free map
// search picked.
// the next request is taken in the cycle the result is shown.
// after reset a clearing pass over every slot sets every generation to one
// and clears the alive bitmap; busy stays high throughout.
// results cannot be held off; done is a one-cycle strobe.
module generational_handle_table_core #(
    parameter int CAPACITY = ght_pkg::CAPACITY_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  ght_pkg::req_t request,
    output logic          done,
    output ght_pkg::rsp_t result
);

    localparam int NWORDS = (CAPACITY + ght_pkg::BMP_W - 1) / ght_pkg::BMP_W;
    localparam int IW     = CAPACITY > 1 ? $clog2(CAPACITY) : 1;
    localparam logic [16:0] CAP17    = 17'(CAPACITY);
    localparam logic [16:0] NWORDS17 = 17'(NWORDS);
    localparam logic [IW-1:0] LAST_SLOT = IW'(CAPACITY - 1);

    ght_pkg::state_t state_reg, state_next;
    logic [IW-1:0]                   clr_reg, clr_next;
    logic [1:0]                      op_reg;
    logic [ght_pkg::HANDLE_W-1:0]    handle_reg;
    logic [ght_pkg::FM_WORD_W-1:0]   word_reg, word_next;
    logic                            exh_reg;
    logic [IW-1:0]                   slot_reg, slot_next;
    logic                            done_reg, done_next;
    ght_pkg::rsp_t                   result_reg, result_next;

    ght_pkg::fm_cmd_t  fm_cmd;
    ght_pkg::fm_stat_t fm_stat;

    logic                      gen_we, gen_re;
    logic [IW-1:0]             gen_waddr, gen_raddr;
    logic [ght_pkg::GEN_W-1:0] gen_wdata, gen_rdata;

    logic                       accept;
    logic [15:0]                in_idx;
    logic                       in_range_in;
    logic [15:0]                chk_idx;
    logic                       chk_range;
    logic                       chk_valid;
    logic [ght_pkg::BMP_W-1:0]  free_bits;
    logic [ght_pkg::BMP_SH-1:0] free_pos;
    logic [15:0]                slot_wide;

    ght_free_map #(
        .CAPACITY (CAPACITY)
    ) u_free_map (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (fm_cmd),
        .stat  (fm_stat)
    );

    ght_ram #(
        .WIDTH (ght_pkg::GEN_W),
        .DEPTH (CAPACITY)
    ) u_gen_ram (
        .clk   (clk),
        .we    (gen_we),
        .waddr (gen_waddr),
        .wdata (gen_wdata),
        .re    (gen_re),
        .raddr (gen_raddr),
        .rdata (gen_rdata)
    );

    assign busy   = state_reg != ght_pkg::S_IDLE;
    assign accept = start && !busy;
    assign done   = done_reg;
    assign result = result_reg;

    // handle decode for the incoming request and for the one under check
    assign in_idx      = request.handle_in[15:0] - 16'd1;
    assign in_range_in = (request.handle_in[15:0] != 16'd0) && ({1'b0, in_idx} < CAP17);
    assign chk_idx     = handle_reg[15:0] - 16'd1;
    assign chk_range   = (handle_reg[15:0] != 16'd0) && ({1'b0, chk_idx} < CAP17);
    assign chk_valid   = chk_range && fm_stat.rd_data[chk_idx[ght_pkg::BMP_SH-1:0]]
                         && (gen_rdata == handle_reg[31:16]);

    assign free_bits = fm_stat.rd_data | ~ght_pkg::bmp_mask(word_reg, CAPACITY);
    assign free_pos  = ght_pkg::first_zero(free_bits);
    assign slot_wide = {word_reg, free_pos};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ght_pkg::S_CLEAR:
            begin
                if (clr_reg == LAST_SLOT)
                begin
                    state_next = ght_pkg::S_IDLE;
                end
            end
            ght_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = ght_pkg::S_CHECK;
                end
            end
            ght_pkg::S_CHECK:
            begin
                if (op_reg == ght_pkg::OP_ALLOC && !exh_reg)
                begin
                    state_next = ght_pkg::S_ALLOC;
                end
                else
                begin
                    state_next = ght_pkg::S_IDLE;
                end
            end
            ght_pkg::S_ALLOC:
            begin
                state_next = ght_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ght_pkg::S_IDLE;
            end
        endcase
    end

    // memory controls and results
    always_comb
    begin
        fm_cmd      = '0;
        gen_we      = 1'b0;
        gen_waddr   = '0;
        gen_wdata   = ght_pkg::GEN_RESET;
        gen_re      = 1'b0;
        gen_raddr   = '0;
        clr_next    = clr_reg;
        word_next   = word_reg;
        slot_next   = slot_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        unique case (state_reg)
            ght_pkg::S_CLEAR:
            begin
                gen_we         = 1'b1;
                gen_waddr      = clr_reg;
                fm_cmd.wr      = {1'b0, 16'(clr_reg)} < NWORDS17;
                fm_cmd.wr_word = ght_pkg::FM_WORD_W'(clr_reg);
                clr_next       = clr_reg + IW'(1);
            end
            ght_pkg::S_IDLE:
            begin
                if (start)
                begin
                    if (request.opcode == ght_pkg::OP_ALLOC)
                    begin
                        word_next = fm_stat.first_word;
                    end
                    else if (in_range_in)
                    begin
                        word_next = ght_pkg::FM_WORD_W'(in_idx >> ght_pkg::BMP_SH);
                    end
                    else
                    begin
                        word_next = '0;
                    end
                    fm_cmd.rd      = 1'b1;
                    fm_cmd.rd_word = word_next;
                    gen_re         = 1'b1;
                    gen_raddr      = in_range_in ? in_idx[IW-1:0] : '0;
                end
            end
            ght_pkg::S_CHECK:
            begin
                result_next = '{handle_out: '0, slot_index: '0,
                                status: ght_pkg::ST_INVALID};
                unique case (op_reg)
                    ght_pkg::OP_ALLOC:
                    begin
                        if (exh_reg)
                        begin
                            done_next          = 1'b1;
                            result_next.status = ght_pkg::ST_EXHAUSTED;
                        end
                        else
                        begin
                            fm_cmd.wr      = 1'b1;
                            fm_cmd.wr_word = word_reg;
                            fm_cmd.wr_data = fm_stat.rd_data
                                             | (ght_pkg::BMP_W'(1) << free_pos);
                            slot_next      = slot_wide[IW-1:0];
                            gen_re         = 1'b1;
                            gen_raddr      = slot_next;
                        end
                    end
                    ght_pkg::OP_RELEASE:
                    begin
                        done_next = 1'b1;
                        if (chk_valid)
                        begin
                            fm_cmd.wr      = 1'b1;
                            fm_cmd.wr_word = word_reg;
                            fm_cmd.wr_data = fm_stat.rd_data
                                & ~(ght_pkg::BMP_W'(1) << chk_idx[ght_pkg::BMP_SH-1:0]);
                            gen_we         = 1'b1;
                            gen_waddr      = chk_idx[IW-1:0];
                            gen_wdata      = (gen_rdata == ght_pkg::GEN_MAX)
                                             ? ght_pkg::GEN_RESET
                                             : gen_rdata + 16'd1;
                            result_next    = '{handle_out: handle_reg,
                                               slot_index: 8'(chk_idx),
                                               status: ght_pkg::ST_OK};
                        end
                    end
                    ght_pkg::OP_LOOKUP:
                    begin
                        done_next = 1'b1;
                        if (chk_valid)
                        begin
                            result_next = '{handle_out: handle_reg,
                                            slot_index: 8'(chk_idx),
                                            status: ght_pkg::ST_OK};
                        end
                    end
                    default:
                    begin
                        done_next = 1'b1;
                    end
                endcase
            end
            ght_pkg::S_ALLOC:
            begin
                done_next   = 1'b1;
                result_next = '{handle_out: {gen_rdata, 16'(slot_reg) + 16'd1},
                                slot_index: 8'(slot_reg),
                                status: ght_pkg::ST_OK};
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ght_pkg::S_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= request.opcode;
            handle_reg <= request.handle_in;
            exh_reg    <= fm_stat.all_full;
        end
        word_reg   <= word_next;
        slot_reg   <= slot_next;
        result_reg <= result_next;
    end

    // results only appear once the controller is back to taking requests
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy && !done)
        else $error("no check cycle after a transfer");

    a_ok_handle: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == ght_pkg::ST_OK |->
            result.handle_out[15:0] != 16'd0 && result.handle_out[31:16] != 16'd0)
        else $error("ok result with a null handle");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != ght_pkg::ST_OK |->
            result.handle_out == '0 && result.slot_index == '0)
        else $error("failed result carries data");

endmodule

### src/ght_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module ght_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/ght_free_map.sv
// free map: alive bitmap in ram, one word-full flag per bitmap word
// and the search for the lowest word with a free slot; uses ght_pkg, ght_ram
module ght_free_map #(
    parameter int CAPACITY = ght_pkg::CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ght_pkg::fm_cmd_t  cmd,
    output ght_pkg::fm_stat_t stat
);

    localparam int NWORDS = (CAPACITY + ght_pkg::BMP_W - 1) / ght_pkg::BMP_W;
    localparam int WW     = NWORDS > 1 ? $clog2(NWORDS) : 1;

    logic [NWORDS-1:0]          full_reg;
    logic [NWORDS-1:0]          full_next;
    logic [ght_pkg::BMP_W-1:0]  rd_data;
    logic [WW-1:0]              first_idx;

    ght_ram #(
        .WIDTH (ght_pkg::BMP_W),
        .DEPTH (NWORDS)
    ) u_bmp_ram (
        .clk   (clk),
        .we    (cmd.wr),
        .waddr (cmd.wr_word[WW-1:0]),
        .wdata (cmd.wr_data),
        .re    (cmd.rd),
        .raddr (cmd.rd_word[WW-1:0]),
        .rdata (rd_data)
    );

    // padding bits of the last word count as taken
    always_comb
    begin
        full_next = full_reg;
        if (cmd.wr)
        begin
            full_next[cmd.wr_word[WW-1:0]] =
                &(cmd.wr_data | ~ght_pkg::bmp_mask(cmd.wr_word, CAPACITY));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= '0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_comb
    begin
        first_idx = '0;
        for (int i = NWORDS - 1; i >= 0; i--)
        begin
            if (!full_reg[i])
            begin
                first_idx = WW'(i);
            end
        end
    end

    assign stat.rd_data    = rd_data;
    assign stat.first_word = ght_pkg::FM_WORD_W'(first_idx);
    assign stat.all_full   = &full_reg;

endmodule
